@@ sv/clipped_line_rasterizer_core_macros.svh @@
// ----------------------------------------------------------------------------
// clipped line rasterizer assertion macros
// shared clocked assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTERIZER_CORE_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_CORE_MACROS_SVH

// checked only while out of reset
`define CLR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define CLR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// clr_pkg
// constants and codes of the clipped line rasterizer
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int SCREEN_COLS_DEF = 320;
  localparam int SCREEN_ROWS_DEF = 200;

  localparam int COORD_W   = 11;
  localparam int PIX_W     = COORD_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = PIX_W + FRAC_BITS;
  localparam int DIV_STEPS = COORD_W + FRAC_BITS;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int COLOR_W   = 4;
  localparam int COUNT_W   = 12;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam logic [FRAC_BITS-1:0] HALF_UNIT = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [POS_W-1:0] UNIT_STEP = POS_W'(1) << FRAC_BITS;

  localparam logic signed [COORD_W-1:0] CLIP_LEFT_RST   = COORD_W'(0);
  localparam logic signed [COORD_W-1:0] CLIP_TOP_RST    = COORD_W'(0);
  localparam logic signed [COORD_W-1:0] CLIP_RIGHT_RST  = COORD_W'(319);
  localparam logic signed [COORD_W-1:0] CLIP_BOTTOM_RST = COORD_W'(199);

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    WM_REPLACE     = 2'd0,
    WM_TRANSPARENT = 2'd1,
    WM_XOR         = 2'd2,
    WM_INV_TRANS   = 2'd3
  } wmode_t;

  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_READ = 1'b1
  } item_mode_t;

endpackage

@@ sv/clipped_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core
// 12.16 dda line drawing into a 4 bit per pixel frame store with clipping
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  in       input      in_valid / in_stall          mode, line ends, pen, read pos
//  out      output     out_valid / out_stall        pixel_value, pixels_drawn
//  cfg      input      apb psel/penable/pwrite      clip rectangle registers
//
//  draw item: for a major delta n > 0 the slope divider, a sign step, one pixel
//  per cycle and a pipeline drain; a single point skips divider and sign step
//  read item: the read address, then the registered read of the frame store
//  after reset a clearing pass writes zero to every pixel, one per cycle,
//  SCREEN_COLS * SCREEN_ROWS pixels (64000 by default), in_stall held high
//  a finished item waits in the output register; the next item is taken
//  meanwhile and holds in its last state only if out is still stalled
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core
  import clr_pkg::*;
#(
  parameter int SCREEN_COLS = SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic signed [COORD_W-1:0]  in_start_x,
  input  logic signed [COORD_W-1:0]  in_start_y,
  input  logic signed [COORD_W-1:0]  in_end_x,
  input  logic signed [COORD_W-1:0]  in_end_y,
  input  logic [1:0]                 in_write_mode,
  input  logic [COLOR_W-1:0]         in_pen_color,
  input  logic [8:0]                 in_read_x,
  input  logic [7:0]                 in_read_y,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COLOR_W-1:0]         out_pixel_value,
  output logic [COUNT_W-1:0]         out_pixels_drawn,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [CFG_AW-1:0]          cfg_paddr,
  input  logic [CFG_DW-1:0]          cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  localparam int DEPTH  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam logic signed [PIX_W-1:0] COLS_S = PIX_W'(SCREEN_COLS);
  localparam logic signed [PIX_W-1:0] ROWS_S = PIX_W'(SCREEN_ROWS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(DIV_STEPS - 1);
  localparam logic [COORD_W-1:0] RD_COLS  = COORD_W'(SCREEN_COLS);
  localparam logic [COORD_W-1:0] RD_ROWS  = COORD_W'(SCREEN_ROWS);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DIV    = 9'b000000100,
    ST_DSIGN  = 9'b000001000,
    ST_DRAW   = 9'b000010000,
    ST_DRAIN  = 9'b000100000,
    ST_RDADDR = 9'b001000000,
    ST_RDWAIT = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [COORD_W-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  // line set-up
  logic signed [PIX_W-1:0]  dx, dy;
  logic [PIX_W-1:0]         adx_full, ady_full;
  logic [COORD_W-1:0]       adx, ady;
  logic                     y_major;
  logic                     accept;

  // per-item registers
  logic [ADDR_W-1:0]        clr_cnt_r;
  logic signed [POS_W-1:0]  px_r, py_r, sx_r, sy_r;
  logic [COORD_W-1:0]       n_r, pt_r;
  logic                     y_major_r, step_neg_r, minor_neg_r;
  wmode_t                   wmode_r;
  logic [COLOR_W-1:0]       color_r;
  logic [DIV_STEPS-1:0]     div_q_r;
  logic [COORD_W-1:0]       div_rem_r;
  logic [DCNT_W-1:0]        div_cnt_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  logic                     rd_inrange_r;
  logic [COLOR_W-1:0]       res_pix_r;
  logic [COUNT_W-1:0]       cnt_r;

  // divider step
  logic [COORD_W:0]         rem_sh;
  logic                     rem_ge;

  // slope application
  logic signed [POS_W-1:0]  quo_ext, slope, major_step;

  // pixel test
  logic signed [PIX_W-1:0]  ix, iy;
  logic signed [PIX_W-1:0]  cl_e, ct_e, cr_e, cb_e;
  logic                     pix_pass;
  logic [ADDR_W-1:0]        pix_addr;

  // write pipeline
  logic                     p1_valid_r, p1_pass_r, p2_valid_r, p2_pass_r;
  logic [ADDR_W-1:0]        p1_addr_r, p2_addr_r;

  // frame store
  logic [COLOR_W-1:0]       mem [DEPTH];
  logic [COLOR_W-1:0]       mem_rdata_r;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [COLOR_W-1:0]       mem_wdata;

  logic                     out_valid_r;
  logic [COLOR_W-1:0]       out_pix_r;
  logic [COUNT_W-1:0]       out_cnt_r;
  logic                     out_load;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= CLIP_LEFT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_right_r  <= CLIP_RIGHT_RST;
      clip_bottom_r <= CLIP_BOTTOM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CLIP_LEFT:   clip_left_r   <= cfg_pwdata[COORD_W-1:0];
        REG_CLIP_TOP:    clip_top_r    <= cfg_pwdata[COORD_W-1:0];
        REG_CLIP_RIGHT:  clip_right_r  <= cfg_pwdata[COORD_W-1:0];
        REG_CLIP_BOTTOM: clip_bottom_r <= cfg_pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CLIP_LEFT:   cfg_prdata = {{(CFG_DW-COORD_W){clip_left_r[COORD_W-1]}}, clip_left_r};
      REG_CLIP_TOP:    cfg_prdata = {{(CFG_DW-COORD_W){clip_top_r[COORD_W-1]}}, clip_top_r};
      REG_CLIP_RIGHT:  cfg_prdata = {{(CFG_DW-COORD_W){clip_right_r[COORD_W-1]}}, clip_right_r};
      REG_CLIP_BOTTOM: cfg_prdata = {{(CFG_DW-COORD_W){clip_bottom_r[COORD_W-1]}},
                                     clip_bottom_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- set-up
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign dx       = {in_end_x[COORD_W-1], in_end_x} - {in_start_x[COORD_W-1], in_start_x};
  assign dy       = {in_end_y[COORD_W-1], in_end_y} - {in_start_y[COORD_W-1], in_start_y};
  assign adx_full = dx[PIX_W-1] ? PIX_W'(-dx) : dx;
  assign ady_full = dy[PIX_W-1] ? PIX_W'(-dy) : dy;
  assign adx      = adx_full[COORD_W-1:0];
  assign ady      = ady_full[COORD_W-1:0];
  assign y_major  = (adx < ady);

  // ---------------------------------------------------------------- divider
  assign rem_sh = {div_rem_r, div_q_r[DIV_STEPS-1]};
  assign rem_ge = (rem_sh >= {1'b0, n_r});

  assign quo_ext    = {{(POS_W-QUO_W){1'b0}}, div_q_r[QUO_W-1:0]};
  assign slope      = minor_neg_r ? -quo_ext : quo_ext;
  assign major_step = step_neg_r ? -UNIT_STEP : UNIT_STEP;

  // ---------------------------------------------------------------- pixel test
  assign ix   = px_r[POS_W-1:FRAC_BITS];
  assign iy   = py_r[POS_W-1:FRAC_BITS];
  assign cl_e = {clip_left_r[COORD_W-1], clip_left_r};
  assign ct_e = {clip_top_r[COORD_W-1], clip_top_r};
  assign cr_e = {clip_right_r[COORD_W-1], clip_right_r};
  assign cb_e = {clip_bottom_r[COORD_W-1], clip_bottom_r};

  assign pix_pass = (ix >= cl_e) && (ix <= cr_e) && (iy >= ct_e) && (iy <= cb_e) &&
                    !ix[PIX_W-1] && (ix < COLS_S) && !iy[PIX_W-1] && (iy < ROWS_S);
  assign pix_addr = ADDR_W'(iy[ROW_W-1:0]) * COLS_A + ADDR_W'(ix[COL_W-1:0]);

  // ---------------------------------------------------------------- control
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_cnt_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_READ) begin
            state_nxt = ST_RDADDR;
          end else if ((y_major ? ady : adx) == '0) begin
            state_nxt = ST_DRAW;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV:    if (div_cnt_r == DIV_LAST) state_nxt = ST_DSIGN;
      ST_DSIGN:  state_nxt = ST_DRAW;
      ST_DRAW:   if (pt_r == n_r) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!p1_valid_r && !p2_valid_r) state_nxt = ST_DONE;
      ST_RDADDR: state_nxt = ST_RDWAIT;
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p1_valid_r <= (state_r == ST_DRAW);
      p2_valid_r <= p1_valid_r;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    p1_pass_r <= pix_pass;
    p1_addr_r <= pix_addr;
    p2_pass_r <= p1_pass_r;
    p2_addr_r <= p1_addr_r;
    if (p2_valid_r && p2_pass_r) cnt_r <= cnt_r + 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          px_r         <= {in_start_x[COORD_W-1], in_start_x, HALF_UNIT};
          py_r         <= {in_start_y[COORD_W-1], in_start_y, HALF_UNIT};
          sx_r         <= '0;
          sy_r         <= '0;
          y_major_r    <= y_major;
          n_r          <= y_major ? ady : adx;
          step_neg_r   <= y_major ? dy[PIX_W-1] : dx[PIX_W-1];
          minor_neg_r  <= y_major ? dx[PIX_W-1] : dy[PIX_W-1];
          div_q_r      <= {(y_major ? adx : ady), {FRAC_BITS{1'b0}}};
          div_rem_r    <= '0;
          div_cnt_r    <= '0;
          pt_r         <= '0;
          wmode_r      <= wmode_t'(in_write_mode);
          color_r      <= in_pen_color;
          cnt_r        <= '0;
          res_pix_r    <= '0;
          rd_addr_r    <= ADDR_W'(in_read_y) * COLS_A + ADDR_W'(in_read_x);
          rd_inrange_r <= (COORD_W'(in_read_x) < RD_COLS) && (COORD_W'(in_read_y) < RD_ROWS);
        end
      end
      ST_DIV: begin
        div_rem_r <= rem_ge ? COORD_W'(rem_sh - {1'b0, n_r}) : rem_sh[COORD_W-1:0];
        div_q_r   <= {div_q_r[DIV_STEPS-2:0], rem_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      ST_DSIGN: begin
        sx_r <= y_major_r ? slope : major_step;
        sy_r <= y_major_r ? major_step : slope;
      end
      ST_DRAW: begin
        px_r <= px_r + sx_r;
        py_r <= py_r + sy_r;
        pt_r <= pt_r + 1'b1;
      end
      ST_RDWAIT: res_pix_r <= rd_inrange_r ? mem_rdata_r : '0;
      default: ;
    endcase
    if (out_load) begin
      out_pix_r <= res_pix_r;
      out_cnt_r <= cnt_r;
    end
  end

  // ---------------------------------------------------------------- frame store
  // a line never revisits a pixel, so a xor read and the write of the
  // previous pixel never share an address
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = p2_valid_r && p2_pass_r && (wmode_r != WM_INV_TRANS);
      mem_waddr = p2_addr_r;
      mem_wdata = (wmode_r == WM_XOR) ? (mem_rdata_r ^ color_r) : color_r;
    end
  end

  assign mem_raddr = (state_r == ST_RDADDR) ? rd_addr_r : p1_addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pix_r;
  assign out_pixels_drawn = out_cnt_r;

endmodule

@@ sv/clr_checker.sv @@
// ----------------------------------------------------------------------------
// clr_checker
// port level checks of the clipped line rasterizer
// ----------------------------------------------------------------------------
`include "clipped_line_rasterizer_core_macros.svh"

module clr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_pixel_value,
  input logic [11:0] out_pixels_drawn
);

  // a stalled result holds
  `CLR_ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_pixel_value) && $stable(out_pixels_drawn), "result changed under stall")

  // one item at a time
  `CLR_ASSERT_CLK(a_one_item, clk, rst_n, in_valid && !in_stall |=> in_stall, "item taken while busy")

  // a read never counts, a draw never returns a pixel
  `CLR_ASSERT_CLK(a_result_kind, clk, rst_n, out_valid |-> (out_pixel_value == 4'd0 || out_pixels_drawn == 12'd0), "mixed result fields")

  `CLR_ASSERT_CLK(a_count_max, clk, rst_n, out_valid |-> (out_pixels_drawn <= 12'd2048), "count beyond longest line")

  // reset empties the output and starts the clearing pass
  `CLR_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_valid && in_stall, "bad state after reset")

endmodule

bind clipped_line_rasterizer_core clr_checker u_clr_checker (.*);
